FILE: design/gdm5_pkg.sv
// ----------------------------------------------------------------------------
// gdm5_pkg
// Shared types and constants for the gated dual median filter.
// ----------------------------------------------------------------------------
package gdm5_pkg;

	// sample and register widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LIMIT_W  = 16;

	// glitch limit after reset
	localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RESET = 16'd64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [LIMIT_W-1:0]         limit_t;
	typedef logic [SAMPLE_W:0]          magnitude_t;

	// control from the pipeline to each window
	typedef struct packed {
		logic advance;
		logic reject;
	} win_ctrl_t;

endpackage

FILE: design/gdm5_window.sv
// ----------------------------------------------------------------------------
// gdm5_window
// One sample window with its median: shifts a new sample in and picks the
// middle element of the descending order by rank counting.
// ----------------------------------------------------------------------------
module gdm5_window #(
	parameter int unsigned WINDOW_DEPTH = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gdm5_pkg::win_ctrl_t ctrl,
	input  gdm5_pkg::sample_t  sample,
	output gdm5_pkg::sample_t  median
);

	localparam int unsigned RANK_W = $clog2(WINDOW_DEPTH);
	localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_DEPTH / 2);

	logic [WINDOW_DEPTH-1:0][gdm5_pkg::SAMPLE_W-1:0] win_q;
	logic [WINDOW_DEPTH-1:0][gdm5_pkg::SAMPLE_W-1:0] win_nxt;
	gdm5_pkg::sample_t  last_q;
	gdm5_pkg::sample_t  new_median;
	logic [RANK_W-1:0]  rank [WINDOW_DEPTH];

	// window after the new sample is shifted in at the front
	always_comb begin
		win_nxt[0] = sample;
		for (int k = 1; k < WINDOW_DEPTH; k++) begin
			win_nxt[k] = win_q[k-1];
		end
	end

	// rank of each entry in descending order, ties broken by position
	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				if (j != i) begin
					if ($signed(win_nxt[j]) > $signed(win_nxt[i])) begin
						rank[i] = rank[i] + RANK_W'(1);
					end else if ((j < i) && (win_nxt[j] == win_nxt[i])) begin
						rank[i] = rank[i] + RANK_W'(1);
					end
				end
			end
		end
	end

	// exactly one entry holds the middle rank
	always_comb begin
		new_median = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (rank[i] == MID_RANK) begin
				new_median = new_median | gdm5_pkg::sample_t'(win_nxt[i]);
			end
		end
	end

	// a rejected word repeats the last median
	assign median = ctrl.reject ? last_q : new_median;

	// window and last median update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			last_q <= '0;
		end else if (ctrl.advance && !ctrl.reject) begin
			win_q  <= win_nxt;
			last_q <= new_median;
		end
	end

	// rejected words leave the window alone
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance && ctrl.reject |=> $stable(win_q) && $stable(last_q))
		else $error("window changed on a rejected word");

	// accepted words store the median that was given out
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance && !ctrl.reject |=> last_q == $past(median))
		else $error("last median differs from the median given");

	// accepted words land at the front of the window
	a_front_sample: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance && !ctrl.reject |=> win_q[0] == $past(sample))
		else $error("front of the window is not the accepted sample");

endmodule

FILE: design/gated_dual_median5_filter.sv
// ----------------------------------------------------------------------------
// gated_dual_median5_filter
// Median filter over left and right encoder deltas; a pair with a sample at
// or above the glitch limit is dropped and the previous medians repeat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_stall   left_delta, right_delta
//  out       from block out_valid / out_stall left_median, right_median, rejected
//  config    to block   glitch_limit_we       glitch_limit_wdata
//
// one word per cycle sustained while out_stall is low; a word passes the input
// register, then the rank-count median network into the result register.
// reset clears both windows and last medians to zero, limit to 64.
// the input register still takes a word while a result waits under out_stall;
// in_stall rises only when both registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module gated_dual_median5_filter #(
	parameter int unsigned WINDOW_DEPTH = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              glitch_limit_we,
	input  gdm5_pkg::limit_t  glitch_limit_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  gdm5_pkg::sample_t left_delta,
	input  gdm5_pkg::sample_t right_delta,
	output logic              out_valid,
	input  logic              out_stall,
	output gdm5_pkg::sample_t left_median,
	output gdm5_pkg::sample_t right_median,
	output logic              rejected
);

	gdm5_pkg::limit_t     limit_q;
	logic                 valid_s1;
	gdm5_pkg::sample_t    left_s1;
	gdm5_pkg::sample_t    right_s1;
	logic                 valid_s2;
	gdm5_pkg::sample_t    left_s2;
	gdm5_pkg::sample_t    right_s2;
	logic                 rejected_s2;
	logic                 in_accept;
	logic                 advance;
	gdm5_pkg::magnitude_t left_mag;
	gdm5_pkg::magnitude_t right_mag;
	logic                 reject;
	gdm5_pkg::win_ctrl_t  win_ctrl;
	gdm5_pkg::sample_t    left_med;
	gdm5_pkg::sample_t    right_med;

	// glitch limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gdm5_pkg::GLITCH_LIMIT_RESET;
		end else if (glitch_limit_we) begin
			limit_q <= glitch_limit_wdata;
		end
	end

	// handshake
	assign advance   = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			left_s1  <= left_delta;
			right_s1 <= right_delta;
		end
	end

	// magnitudes with one extra bit so the most negative sample fits
	assign left_mag  = left_s1[gdm5_pkg::SAMPLE_W-1]
		? (~{left_s1[gdm5_pkg::SAMPLE_W-1], left_s1} + 1'b1)
		: {1'b0, left_s1};
	assign right_mag = right_s1[gdm5_pkg::SAMPLE_W-1]
		? (~{right_s1[gdm5_pkg::SAMPLE_W-1], right_s1} + 1'b1)
		: {1'b0, right_s1};

	assign reject = (left_mag >= {1'b0, limit_q}) || (right_mag >= {1'b0, limit_q});

	assign win_ctrl.advance = advance;
	assign win_ctrl.reject  = reject;

	// one window per side
	gdm5_window #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_left_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.sample (left_s1),
		.median (left_med)
	);

	gdm5_window #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_right_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.sample (right_s1),
		.median (right_med)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2     <= left_med;
			right_s2    <= right_med;
			rejected_s2 <= reject;
		end
	end

	assign out_valid    = valid_s2;
	assign left_median  = left_s2;
	assign right_median = right_s2;
	assign rejected     = rejected_s2;

	// a word held in the input register keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(left_s1) && $stable(right_s1))
		else $error("input register lost a held word");

	// a taken result with nothing behind it empties the output
	a_s2_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_stall && !advance |=> !valid_s2)
		else $error("result register did not drain");

	// input is stalled only when the result register is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !advance && valid_s2)
		else $error("input stalled while the pipeline could move");

endmodule

FILE: tb/sv/gated_dual_median5_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gated_dual_median5_filter_test
// Self-checking bench for the gated dual median filter. A directed list of
// words covers reset state, the glitch limit edges and the most negative
// sample. Random phases at several limits follow. Each result word is checked against
// its typed value or a window model, with random idle and stall but for one phase.
// ----------------------------------------------------------------------------
module gated_dual_median5_filter_test;

	localparam int WIN_DEPTH     = 5;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_WORDS   = 136;
	localparam int STALL_PCT     = 17;
	localparam int WATCHDOG_MAX  = 1000;

	typedef enum logic {ROW_PAIR, ROW_LIMIT} row_kind_e;

	typedef struct {
		gdm5_pkg::sample_t left;
		gdm5_pkg::sample_t right;
		logic              rej;
	} medians_t;

	typedef struct {
		row_kind_e         kind;
		gdm5_pkg::limit_t  limit;
		gdm5_pkg::sample_t left;
		gdm5_pkg::sample_t right;
		bit                typed;
		medians_t          want;
	} test_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              glitch_limit_we = 1'b0;
	gdm5_pkg::limit_t  glitch_limit_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	gdm5_pkg::sample_t left_delta = '0;
	gdm5_pkg::sample_t right_delta = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	gdm5_pkg::sample_t left_median;
	gdm5_pkg::sample_t right_median;
	logic              rejected;

	// model state
	gdm5_pkg::sample_t left_win [WIN_DEPTH];
	gdm5_pkg::sample_t right_win [WIN_DEPTH];
	gdm5_pkg::sample_t left_held;
	gdm5_pkg::sample_t right_held;
	gdm5_pkg::limit_t  limit_now;

	medians_t pending_medians [$];
	medians_t head_want;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	bit       no_idle = 1'b0;

	gated_dual_median5_filter dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.glitch_limit_we    (glitch_limit_we),
		.glitch_limit_wdata (glitch_limit_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.left_delta         (left_delta),
		.right_delta        (right_delta),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.left_median        (left_median),
		.right_median       (right_median),
		.rejected           (rejected)
	);

	always #1 clk = ~clk;

	// magnitude as an int so that -32768 gives 32768
	function automatic int tick_magnitude(gdm5_pkg::sample_t v);
		return (v < 0) ? -int'(v) : int'(v);
	endfunction

	// middle element of the descending order
	function automatic gdm5_pkg::sample_t window_median(gdm5_pkg::sample_t win [WIN_DEPTH]);
		int sorted [WIN_DEPTH];
		int t;
		for (int i = 0; i < WIN_DEPTH; i++) sorted[i] = int'(win[i]);
		for (int j = 0; j < WIN_DEPTH; j++) begin
			for (int i = j + 1; i < WIN_DEPTH; i++) begin
				if (sorted[i] > sorted[j]) begin
					t = sorted[i];
					sorted[i] = sorted[j];
					sorted[j] = t;
				end
			end
		end
		return gdm5_pkg::sample_t'(sorted[WIN_DEPTH / 2]);
	endfunction

	// gate the pair, shift both windows and take the medians
	function automatic medians_t filter_pair(gdm5_pkg::sample_t l, gdm5_pkg::sample_t r);
		medians_t res;
		res.rej = (tick_magnitude(l) >= int'(limit_now)) ||
			(tick_magnitude(r) >= int'(limit_now));
		if (!res.rej) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--) begin
				left_win[i] = left_win[i - 1];
				right_win[i] = right_win[i - 1];
			end
			left_win[0] = l;
			right_win[0] = r;
			left_held = window_median(left_win);
			right_held = window_median(right_win);
		end
		res.left = left_held;
		res.right = right_held;
		return res;
	endfunction

	// mostly in-limit samples, some at the limit, some extremes and noise
	function automatic gdm5_pkg::sample_t pick_sample(gdm5_pkg::limit_t lim);
		int unsigned roll;
		int span;
		int v;
		roll = $urandom_range(0, 99);
		span = (lim > 16'd32768) ? 32768 : int'(lim) - 1;
		if (roll < 2) return gdm5_pkg::sample_t'(-32768);
		if (roll < 4) return gdm5_pkg::sample_t'(32767);
		if (roll < 10 || span < 0) return gdm5_pkg::sample_t'($urandom);
		if (roll < 16) begin
			v = span + int'($urandom_range(0, 1));
			return gdm5_pkg::sample_t'($urandom_range(0, 1) ? v : -v);
		end
		v = int'($urandom_range(0, 2 * span)) - span;
		return gdm5_pkg::sample_t'(v);
	endfunction

	function automatic test_row_t row_pair(int l, int r);
		test_row_t row;
		row = '{ROW_PAIR, '0, gdm5_pkg::sample_t'(l), gdm5_pkg::sample_t'(r), 1'b0,
			'{'0, '0, 1'b0}};
		return row;
	endfunction

	function automatic test_row_t row_checked(int l, int r, int wl, int wr, bit rej);
		test_row_t row;
		row = row_pair(l, r);
		row.typed = 1'b1;
		row.want = '{gdm5_pkg::sample_t'(wl), gdm5_pkg::sample_t'(wr), rej};
		return row;
	endfunction

	function automatic test_row_t row_limit(int v);
		test_row_t row;
		row = row_pair(0, 0);
		row.kind = ROW_LIMIT;
		row.limit = gdm5_pkg::limit_t'(v);
		return row;
	endfunction

	// offer one word, hold it until taken, then log what it should give
	task automatic send_pair(gdm5_pkg::sample_t l, gdm5_pkg::sample_t r, bit typed,
		medians_t typed_want);
		medians_t res;
		while (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_delta <= l;
		right_delta <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		res = filter_pair(l, r);
		pending_medians.push_back(typed ? typed_want : res);
	endtask

	// drain the block, then write the glitch limit
	task automatic set_limit(gdm5_pkg::limit_t v);
		in_valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		glitch_limit_we <= 1'b1;
		glitch_limit_wdata <= v;
		@(posedge clk);
		glitch_limit_we <= 1'b0;
		limit_now = v;
	endtask

	// random stall on the result side
	always @(posedge clk) begin
		out_stall <= !no_idle && ($urandom_range(0, 99) < STALL_PCT);
	end

	// result checker
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_medians.size() == 0) begin
				$error("result word with no expected word pending");
				mismatches++;
			end else begin
				head_want = pending_medians.pop_front();
				if (left_median !== head_want.left) begin
					$error("left_median expected %0d actual %0d", head_want.left, left_median);
					mismatches++;
				end
				if (right_median !== head_want.right) begin
					$error("right_median expected %0d actual %0d",
						head_want.right, right_median);
					mismatches++;
				end
				if (rejected !== head_want.rej) begin
					$error("rejected expected %0d actual %0d", head_want.rej, rejected);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		test_row_t        rows [$];
		gdm5_pkg::limit_t phase_limits [RANDOM_PHASES];
		medians_t         none;

		none = '{'0, '0, 1'b0};
		limit_now = gdm5_pkg::GLITCH_LIMIT_RESET;
		left_held = '0;
		right_held = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			left_win[i] = '0;
			right_win[i] = '0;
		end

		// reset state, limit edges, most negative sample
		rows.push_back(row_checked(0, 0, 0, 0, 1'b0));
		rows.push_back(row_checked(64, 0, 0, 0, 1'b1));
		rows.push_back(row_checked(0, -64, 0, 0, 1'b1));
		rows.push_back(row_checked(63, -63, 0, 0, 1'b0));
		rows.push_back(row_checked(63, -63, 0, 0, 1'b0));
		rows.push_back(row_checked(63, -63, 63, -63, 1'b0));
		rows.push_back(row_checked(32767, 5, 63, -63, 1'b1));
		rows.push_back(row_checked(-32768, 0, 63, -63, 1'b1));
		rows.push_back(row_limit(0));
		rows.push_back(row_checked(0, 0, 63, -63, 1'b1));
		rows.push_back(row_limit(1));
		rows.push_back(row_pair(0, 0));
		rows.push_back(row_pair(1, 0));
		rows.push_back(row_pair(0, -1));
		rows.push_back(row_limit(16'hFFFF));
		rows.push_back(row_pair(-32768, 32767));
		rows.push_back(row_pair(-32768, -32768));
		rows.push_back(row_pair(-32768, 32767));
		rows.push_back(row_pair(-32768, 32767));
		rows.push_back(row_pair(32767, -32768));
		rows.push_back(row_limit(16'h8000));
		rows.push_back(row_pair(-32768, 0));
		rows.push_back(row_pair(32767, -32767));
		rows.push_back(row_limit(16'h8001));
		rows.push_back(row_pair(-32768, -32768));
		rows.push_back(row_pair(16'h5555, 16'hAAAA));

		phase_limits = '{gdm5_pkg::limit_t'($urandom_range(2, 200)), 16'hFFFF, 16'h8000,
			gdm5_pkg::limit_t'($urandom_range(1, 65535)), gdm5_pkg::GLITCH_LIMIT_RESET,
			16'd1, gdm5_pkg::limit_t'($urandom_range(200, 5000))};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_LIMIT) begin
				set_limit(rows[i].limit);
			end else begin
				send_pair(rows[i].left, rows[i].right, rows[i].typed, rows[i].want);
			end
		end

		// random phases, one of them with no idle or stall at all
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_limit(phase_limits[p]);
			no_idle = (p == 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				send_pair(pick_sample(limit_now), pick_sample(limit_now), 1'b0, none);
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		// drain and let the pipeline settle
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
